// ===== hdl/u2a_pkg.sv =====
// ---------------------------------------------------------------------------
// u2a_pkg: shared types and constants
// Word formats, opcodes, queue sizing and digit helpers for the unsigned to
// ASCII digit converter.
// ---------------------------------------------------------------------------
package u2a_pkg;

  localparam logic [1:0] OP_DEC32  = 2'd0;
  localparam logic [1:0] OP_HEXL32 = 2'd1;
  localparam logic [1:0] OP_HEXU32 = 2'd2;
  localparam logic [1:0] OP_HEXL64 = 2'd3;

  // starting digit position per mode (most significant digit index)
  localparam logic [3:0] POS_DEC32 = 4'd9;
  localparam logic [3:0] POS_HEX32 = 4'd7;
  localparam logic [3:0] POS_HEX64 = 4'd15;

  // two-entry queues
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;
  localparam logic [Q_CNT_W-1:0] Q_FULL_CNT = Q_CNT_W'(Q_DEPTH);

  localparam logic [7:0] CHAR_0  = 8'h30;
  localparam logic [7:0] CHAR_LA = 8'h61;
  localparam logic [7:0] CHAR_UA = 8'h41;

  localparam logic [31:0] POW10 [10] = '{
    32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000,
    32'd1000000, 32'd10000000, 32'd100000000, 32'd1000000000
  };

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] value;
  } in_word_t;

  typedef struct packed {
    logic [7:0] digit_char;
    logic       last;
  } out_word_t;

  // classified command handed from front to back
  typedef struct packed {
    logic        is_dec;
    logic        upper;
    logic [3:0]  top_pos;
    logic [63:0] value;
  } cmd_t;

  // m * 10^pos, wide enough for 9 * 10^9
  function automatic logic [33:0] dec_multiple(logic [3:0] pos, logic [3:0] m);
    logic [31:0] p;
    p = (pos <= 4'd9) ? POW10[pos] : 32'd0;
    return {2'b00, p} * {30'd0, m};
  endfunction

  function automatic logic [7:0] digit_to_char(logic [3:0] d, logic upper);
    logic [7:0] base;
    base = upper ? CHAR_UA : CHAR_LA;
    if (d < 4'd10) return CHAR_0 + {4'd0, d};
    return base + {4'd0, d} - 8'd10;
  endfunction

endpackage

// ===== hdl/u2a_front.sv =====
// ---------------------------------------------------------------------------
// u2a_front: input classifier and command queue
// Decodes the opcode into mode, case and start position, aligns the value
// and holds up to two commands for the back end.
// ---------------------------------------------------------------------------
module u2a_front import u2a_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  output logic     in_full,
  input  in_word_t in_word,
  output logic     cmd_empty,
  input  logic     cmd_pop,
  output cmd_t     cmd
);

  cmd_t               cls;
  cmd_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               push_ok, pop_ok;

  // hex32 value goes to the top half so the back always shifts nibbles out of [63:60]
  always_comb begin
    cls.is_dec = (in_word.opcode == OP_DEC32);
    cls.upper  = (in_word.opcode == OP_HEXU32);
    unique case (in_word.opcode)
      OP_DEC32: begin
        cls.top_pos = POS_DEC32;
        cls.value   = {32'd0, in_word.value[31:0]};
      end
      OP_HEXL32, OP_HEXU32: begin
        cls.top_pos = POS_HEX32;
        cls.value   = {in_word.value[31:0], 32'd0};
      end
      default: begin
        cls.top_pos = POS_HEX64;
        cls.value   = in_word.value;
      end
    endcase
  end

  assign in_full   = (cnt_r == Q_FULL_CNT);
  assign cmd_empty = (cnt_r == '0);
  assign push_ok   = in_push && !in_full;
  assign pop_ok    = cmd_pop && !cmd_empty;
  assign cmd       = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push_ok && !pop_ok) cnt_nxt = cnt_r + 1'b1;
    else if (!push_ok && pop_ok) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push_ok) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop_ok)  rd_ptr_r <= rd_ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) mem_r[wr_ptr_r] <= cls;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= Q_FULL_CNT) else $error("front queue count out of range");

  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) || (cnt_r == Q_FULL_CNT) || (wr_ptr_r != rd_ptr_r))
    else $error("front queue pointers disagree with count");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop_ok && !push_ok |=> cnt_r == $past(cnt_r) - 1'b1)
    else $error("front queue pop lost");

endmodule

// ===== hdl/u2a_back.sv =====
// ---------------------------------------------------------------------------
// u2a_back: digit sequencer and result queue
// Walks digit positions most significant first, one per cycle while the
// result queue has room, drops leading zeros and queues ASCII characters.
// ---------------------------------------------------------------------------
module u2a_back import u2a_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_empty,
  output logic      cmd_pop,
  input  cmd_t      cmd,
  output logic      out_empty,
  input  logic      out_pop,
  output out_word_t out_word
);

  logic               busy_r, started_r, is_dec_r, upper_r;
  logic [3:0]         pos_r;
  logic [63:0]        val_r, val_nxt;
  logic               load, step, emit;
  logic [3:0]         ddig, hdig, digit;
  logic [33:0]        dsub;
  logic [31:0]        new_rem;
  out_word_t          emit_word;

  out_word_t          oq_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] oq_wr_r, oq_rd_r;
  logic [Q_CNT_W-1:0] oq_cnt_r;
  logic               oq_pop;

  assign load    = !busy_r && !cmd_empty;
  assign cmd_pop = load;
  assign step    = busy_r && (oq_cnt_r != Q_FULL_CNT);

  // decimal digit: largest m with m*10^pos <= remainder
  always_comb begin
    ddig = 4'd0;
    dsub = '0;
    for (int m = 1; m <= 9; m++) begin
      if ({2'b00, val_r[31:0]} >= dec_multiple(pos_r, 4'(m))) begin
        ddig = 4'(m);
        dsub = dec_multiple(pos_r, 4'(m));
      end
    end
    new_rem = val_r[31:0] - dsub[31:0];
  end

  assign hdig  = val_r[63:60];
  assign digit = is_dec_r ? ddig : hdig;
  assign emit  = step && ((digit != 4'd0) || started_r || (pos_r == 4'd0));
  assign val_nxt = is_dec_r ? {32'd0, new_rem} : {val_r[59:0], 4'd0};

  assign emit_word.digit_char = digit_to_char(digit, upper_r);
  assign emit_word.last       = (pos_r == 4'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      started_r <= 1'b0;
    end else if (load) begin
      busy_r    <= 1'b1;
      started_r <= 1'b0;
    end else if (step) begin
      if (emit) started_r <= 1'b1;
      if (pos_r == 4'd0) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      val_r    <= cmd.value;
      pos_r    <= cmd.top_pos;
      is_dec_r <= cmd.is_dec;
      upper_r  <= cmd.upper;
    end else if (step) begin
      val_r <= val_nxt;
      pos_r <= pos_r - 1'b1;
    end
  end

  // result queue
  assign out_empty = (oq_cnt_r == '0);
  assign oq_pop    = out_pop && !out_empty;
  assign out_word  = oq_r[oq_rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      if (emit)   oq_wr_r <= oq_wr_r + 1'b1;
      if (oq_pop) oq_rd_r <= oq_rd_r + 1'b1;
      if (emit && !oq_pop) oq_cnt_r <= oq_cnt_r + 1'b1;
      else if (!emit && oq_pop) oq_cnt_r <= oq_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) oq_r[oq_wr_r] <= emit_word;
  end

  a_dec_pos: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && is_dec_r |-> pos_r <= POS_DEC32)
    else $error("decimal position beyond ten digits");

  a_dec_rem: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && is_dec_r && (pos_r < POS_DEC32) |->
      val_r[31:0] < POW10[4'(pos_r + 4'd1)])
    else $error("decimal remainder too large for position");

  a_started_emits: assert property (@(posedge clk) disable iff (!rst_n)
    step && started_r |-> emit)
    else $error("digit dropped after first significant digit");

  a_oq_range: assert property (@(posedge clk) disable iff (!rst_n)
    oq_cnt_r <= Q_FULL_CNT) else $error("result queue count out of range");

endmodule

// ===== hdl/unsigned_to_ascii_digits.sv =====
// ---------------------------------------------------------------------------
// unsigned_to_ascii_digits: binary to ASCII decimal / hex converter
// Converts a 32-bit or 64-bit unsigned value to ASCII digits, most
// significant first, no leading zeros, final digit flagged.
// ---------------------------------------------------------------------------
// Path: the first character passes the command queue, the sequencer load and
//   the result queue; each suppressed leading zero adds a sequencer step.
// Throughput: the back-end sequencer visits every digit position at one per
//   cycle after a load step while the result queue has room; it takes the
//   next command only once the current word is finished.
// Reset: synchronous, active low; clears both queues and the sequencer.
module unsigned_to_ascii_digits import u2a_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_word_t  in_word,
  output logic      out_empty,
  input  logic      out_pop,
  output out_word_t out_word
);

  logic cmd_empty;
  logic cmd_pop;
  cmd_t cmd;

  // front: decode opcode, align value, two-deep command queue
  u2a_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_word   (in_word),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd)
  );

  // back: one digit position per cycle into a two-deep result queue;
  // stalls only when that queue is full
  u2a_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word)
  );

endmodule

// ===== verif/unsigned_to_ascii_digits_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// unsigned_to_ascii_digits_tb: self-checking bench for the digit converter
// Pushes opcode/value words, first from a directed table and then at random.
// Each digit word that comes out is checked against the golden string of its
// vector or a local model of the conversion. Both sides stall in random bursts.
// ---------------------------------------------------------------------------
module unsigned_to_ascii_digits_tb;
  import u2a_pkg::*;

  // directed vector; golden holds the digit string when it is obvious,
  // empty means the local model supplies the digits
  typedef struct {
    logic [1:0]  opcode;
    logic [63:0] value;
    string       golden;
  } vector_t;

  localparam int RANDOM_WORDS = 340;
  localparam int TAIL_WORDS   = 60;   // no idling on either side in the tail
  localparam int SETTLE_CYCLES = 40;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_push = 1'b0;
  logic      in_full;
  in_word_t  in_word = '0;
  logic      out_empty;
  logic      out_pop = 1'b0;
  out_word_t out_word;

  // digit words still owed by the converter, oldest first
  out_word_t owed_digits[$];
  int        fail_count = 0;
  logic      steady = 1'b0;   // set in the tail: no stalls, no gaps
  int        stall_left = 0;

  unsigned_to_ascii_digits dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_word   (in_word),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // -------------------------------------------------------------------------
  // Local model: appends the digits of one input word to owed_digits,
  // most significant first, last flag on the final digit.
  // -------------------------------------------------------------------------
  function automatic void owe_digits(in_word_t w);
    logic [7:0]  lsd_first[16];
    logic [31:0] dec_val;
    logic [63:0] hex_val;
    logic [3:0]  nib;
    logic        upper;
    int          n;
    out_word_t   d;
    n = 0;
    if (w.opcode == OP_DEC32) begin
      dec_val = w.value[31:0];
      do begin
        lsd_first[n] = "0" + 8'(dec_val % 32'd10);
        dec_val = dec_val / 32'd10;
        n++;
      end while (dec_val != 0);
    end else begin
      // 32-bit modes drop the upper half of the value
      hex_val = (w.opcode == OP_HEXL64) ? w.value : {32'd0, w.value[31:0]};
      upper = (w.opcode == OP_HEXU32);
      do begin
        nib = hex_val[3:0];
        if (nib < 4'd10) lsd_first[n] = "0" + {4'd0, nib};
        else lsd_first[n] = (upper ? "A" : "a") + {4'd0, nib} - 8'd10;
        hex_val = hex_val >> 4;
        n++;
      end while (hex_val != 0);
    end
    for (int k = n - 1; k >= 0; k--) begin
      d.digit_char = lsd_first[k];
      d.last = (k == 0);
      owed_digits.push_back(d);
    end
  endfunction

  // -------------------------------------------------------------------------
  // Sender: holds the word until the push is taken (push high, full low at
  // the edge), then books the expected digits and maybe idles a burst.
  // -------------------------------------------------------------------------
  task automatic send_word(input in_word_t w, input string golden);
    out_word_t d;
    in_push <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_full);
    if (golden.len() == 0) begin
      owe_digits(w);
    end else begin
      for (int i = 0; i < golden.len(); i++) begin
        d.digit_char = golden[i];
        d.last = (i == golden.len() - 1);
        owed_digits.push_back(d);
      end
    end
    if (!steady && $urandom_range(0, 3) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // hold the sender until every owed digit has been taken; always waits for a
  // clock edge first so push is never driven twice in one step
  task automatic drain_digits();
    in_push <= 1'b0;
    do @(posedge clk); while (owed_digits.size() != 0);
  endtask

  // -------------------------------------------------------------------------
  // Receiver: pop high most cycles, with stall bursts starting now and then;
  // pop held high in the tail.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
      stall_left <= 0;
    end else if (steady) begin
      out_pop <= 1'b1;
    end else if (stall_left != 0) begin
      out_pop <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_pop <= 1'b0;
      stall_left <= $urandom_range(0, 14);
    end else begin
      out_pop <= 1'b1;
    end
  end

  // -------------------------------------------------------------------------
  // Checker: every digit word taken at an edge is compared with the oldest
  // owed one. Values read here are the ones present before the edge.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (owed_digits.size() == 0) begin
        $error("unexpected digit word: digit_char %h last %b",
               out_word.digit_char, out_word.last);
        fail_count++;
      end else begin
        want = owed_digits.pop_front();
        if (out_word.digit_char !== want.digit_char) begin
          $error("digit_char: expected %h, got %h", want.digit_char, out_word.digit_char);
          fail_count++;
        end
        if (out_word.last !== want.last) begin
          $error("last: expected %b, got %b", want.last, out_word.last);
          fail_count++;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  initial begin
    vector_t  vectors[$];
    in_word_t w;
    int       shift;

    // extremes, digit-count boundaries, zero in every mode and upper bits
    // that the 32-bit modes must ignore
    vectors.push_back('{OP_DEC32,  64'd0,                   "0"});
    vectors.push_back('{OP_DEC32,  64'h0000_0000_FFFF_FFFF, "4294967295"});
    vectors.push_back('{OP_DEC32,  64'hDEAD_BEEF_0000_0000, "0"});
    vectors.push_back('{OP_DEC32,  64'hFFFF_FFFF_0000_000A, "10"});
    vectors.push_back('{OP_DEC32,  64'd9,                   "9"});
    vectors.push_back('{OP_DEC32,  64'd999999999,           "999999999"});
    vectors.push_back('{OP_DEC32,  64'd1000000000,          "1000000000"});
    vectors.push_back('{OP_DEC32,  64'h0000_0000_8000_0000, ""});
    vectors.push_back('{OP_HEXL32, 64'd0,                   "0"});
    vectors.push_back('{OP_HEXL32, 64'h0000_0000_FFFF_FFFF, "ffffffff"});
    vectors.push_back('{OP_HEXL32, 64'h1234_5678_9ABC_DEF0, "9abcdef0"});
    vectors.push_back('{OP_HEXL32, 64'hFFFF_FFFF_0000_000F, "f"});
    vectors.push_back('{OP_HEXL32, 64'h0000_0000_0000_0010, "10"});
    vectors.push_back('{OP_HEXU32, 64'd0,                   "0"});
    vectors.push_back('{OP_HEXU32, 64'h0000_0000_FFFF_FFFF, "FFFFFFFF"});
    vectors.push_back('{OP_HEXU32, 64'hFFFF_FFFF_ABCD_EF01, "ABCDEF01"});
    vectors.push_back('{OP_HEXU32, 64'h0000_0000_0000_0BAD, ""});
    vectors.push_back('{OP_HEXL64, 64'd0,                   "0"});
    vectors.push_back('{OP_HEXL64, 64'hFFFF_FFFF_FFFF_FFFF, "ffffffffffffffff"});
    vectors.push_back('{OP_HEXL64, 64'h8000_0000_0000_0000, "8000000000000000"});
    vectors.push_back('{OP_HEXL64, 64'd1,                   "1"});
    vectors.push_back('{OP_HEXL64, 64'h0123_4567_89AB_CDEF, "123456789abcdef"});
    vectors.push_back('{OP_HEXL64, 64'h0000_0001_0000_0000, ""});

    // synchronous reset
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (vectors[i]) begin
      w.opcode = vectors[i].opcode;
      w.value  = vectors[i].value;
      send_word(w, vectors[i].golden);
    end
    drain_digits();

    // random part: random shift spreads the digit count over its full range
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS / 2) drain_digits();
      if (i == RANDOM_WORDS - TAIL_WORDS) steady <= 1'b1;
      shift = $urandom_range(0, 64);
      w.opcode = 2'($urandom_range(0, 3));
      w.value  = {$urandom(), $urandom()} >> shift;
      send_word(w, "");
    end
    in_push <= 1'b0;

    while (owed_digits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/u2a_pkg.sv
hdl/u2a_front.sv
hdl/u2a_back.sv
hdl/unsigned_to_ascii_digits.sv
verif/unsigned_to_ascii_digits_tb.sv
